@@ design/cfta_pkg.sv @@
// ----------------------------------------------------------------------------
// CAN frame text line package
// Character codes and the hex digit encoder shared by the line formatter.
// ----------------------------------------------------------------------------
package cfta_pkg;

  localparam int unsigned CharW   = 7;
  localparam int unsigned NibbleW = 4;
  localparam int unsigned ShiftW  = 64;

  localparam logic [CharW-1:0] ChHash = 7'h23;
  localparam logic [CharW-1:0] ChR    = 7'h52;
  localparam logic [CharW-1:0] ChCr   = 7'h0D;
  localparam logic [CharW-1:0] ChLf   = 7'h0A;
  localparam logic [CharW-1:0] ChZero = 7'h30;
  localparam logic [CharW-1:0] ChAlph = 7'h37;

  localparam logic [3:0] MaxLen = 4'd8;

  typedef logic [CharW-1:0] char_t;

  // Uppercase hex digit for one nibble.
  function automatic char_t hex_char(input logic [NibbleW-1:0] nib);
    char_t base;
    base = (nib < 4'd10) ? ChZero : ChAlph;
    return base + {3'b000, nib};
  endfunction

endpackage

@@ design/cfta_nibble_shifter.sv @@
// ----------------------------------------------------------------------------
// Nibble shifter
// Holds a left-justified word and gives out its top nibble, moving on by
// four bits on each shift.
// ----------------------------------------------------------------------------
module cfta_nibble_shifter
  import cfta_pkg::*;
(
  input  logic                clk_i,
  input  logic                load_i,
  input  logic [ShiftW-1:0]   load_val_i,
  input  logic                shift_i,
  output logic [NibbleW-1:0]  nibble_o
);

  logic [ShiftW-1:0] word_q;
  logic [ShiftW-1:0] word_d;

  always_comb begin
    word_d = word_q;
    if (load_i) begin
      word_d = load_val_i;
    end else if (shift_i) begin
      word_d = {word_q[ShiftW-NibbleW-1:0], {NibbleW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign nibble_o = word_q[ShiftW-1 -: NibbleW];

endmodule

@@ design/can_frame_to_ascii_line.sv @@
// The first character of a line is registered after the frame transfer moves the
// sequencer to its identifier state. A line has 6 to 27 characters, one per cycle
// while the output is not stalled, made by the sequencer and the single nibble
// shifter; no new frame is taken until the sequencer is back in idle after the line feed.
// Reset clears the sequencer and the output valid flag; the line in progress is lost.
// ----------------------------------------------------------------------------
// CAN frame to ASCII line
// Formats one received CAN frame as a compact text line, one character per
// output transfer, with the final line feed flagged.
// ----------------------------------------------------------------------------
module can_frame_to_ascii_line
  import cfta_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [28:0] frame_id_i,
  input  logic [3:0]  length_code_i,
  input  logic        extended_i,
  input  logic        remote_i,
  input  logic [7:0]  byte0_i,
  input  logic [7:0]  byte1_i,
  input  logic [7:0]  byte2_i,
  input  logic [7:0]  byte3_i,
  input  logic [7:0]  byte4_i,
  input  logic [7:0]  byte5_i,
  input  logic [7:0]  byte6_i,
  input  logic [7:0]  byte7_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  text_char_o,
  output logic        line_end_o
);

  typedef enum logic [2:0] {
    StIdle,
    StId,
    StHash,
    StRtr,
    StLen,
    StData,
    StCr,
    StLf
  } state_e;

  state_e             state_q, state_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [3:0]         len_q, len_d;
  logic               rtr_q, rtr_d;
  logic [ShiftW-1:0]  data_q;
  logic               out_valid_q, out_valid_d;
  char_t              char_q, char_d;
  logic               last_q, last_d;

  logic               accept;
  logic               advance;
  logic               sh_load;
  logic               sh_shift;
  logic [ShiftW-1:0]  sh_val;
  logic [NibbleW-1:0] nibble;
  logic [4:0]         digits;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign advance    = !out_valid_q || !out_stall_i;
  assign digits     = {len_q, 1'b0} - 5'd1;

  cfta_nibble_shifter u_shifter (
    .clk_i      (clk_i),
    .load_i     (sh_load),
    .load_val_i (sh_val),
    .shift_i    (sh_shift),
    .nibble_o   (nibble)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    rtr_d       = rtr_q;
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    sh_load     = 1'b0;
    sh_shift    = 1'b0;
    sh_val      = data_q;

    if (accept) begin
      sh_load = 1'b1;
      sh_val  = extended_i ? {3'b000, frame_id_i, 32'h0}
                           : {1'b0, frame_id_i[10:0], 52'h0};
      cnt_d   = extended_i ? 4'd7 : 4'd2;
      len_d   = (length_code_i > MaxLen) ? MaxLen : length_code_i;
      rtr_d   = remote_i;
      state_d = StId;
    end

    if (advance) begin
      out_valid_d = (state_q != StIdle);
      last_d      = 1'b0;
      unique case (state_q)
        StIdle: begin
        end
        StId, StData: begin
          char_d   = hex_char(nibble);
          sh_shift = 1'b1;
          if (cnt_q == 4'd0) begin
            state_d = (state_q == StId) ? StHash : StCr;
          end else begin
            cnt_d = cnt_q - 4'd1;
          end
        end
        StHash: begin
          char_d = ChHash;
          priority if (rtr_q) begin
            state_d = StRtr;
          end else if (len_q == 4'd0) begin
            state_d = StCr;
          end else begin
            sh_load = 1'b1;
            sh_val  = data_q;
            cnt_d   = digits[3:0];
            state_d = StData;
          end
        end
        StRtr: begin
          char_d  = ChR;
          state_d = StLen;
        end
        StLen: begin
          char_d  = hex_char(len_q);
          state_d = StCr;
        end
        StCr: begin
          char_d  = ChCr;
          state_d = StLf;
        end
        StLf: begin
          char_d  = ChLf;
          last_d  = 1'b1;
          state_d = StIdle;
        end
        default: begin
          state_d = StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      len_q       <= '0;
      rtr_q       <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
      data_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      rtr_q       <= rtr_d;
      char_q      <= char_d;
      last_q      <= last_d;
      if (accept) begin
        data_q <= {byte0_i, byte1_i, byte2_i, byte3_i,
                   byte4_i, byte5_i, byte6_i, byte7_i};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign line_end_o  = last_q;

endmodule

@@ tb/tb_can_frame_to_ascii_line.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN frame to ASCII line testbench
// Sends directed and random CAN frames through the formatter and checks every
// character transfer against a line built locally from the same frame, under
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_can_frame_to_ascii_line;
  import cfta_pkg::*;

  typedef struct packed {
    logic [28:0]     id;
    logic [3:0]      len;
    logic            ext;
    logic            rtr;
    logic [7:0][7:0] data;
  } can_frame_t;

  typedef struct {
    char_t ch;
    logic  last;
  } line_char_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [6:0] text_char_o;
  logic line_end_o;
  can_frame_t cur_frame = '0;

  can_frame_t frames_pending[$];
  line_char_t due_chars[$];
  int unsigned frames_queued = 0;
  int unsigned frames_taken = 0;
  logic taken_now = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;

  always #10 clk_i = ~clk_i;

  can_frame_to_ascii_line dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .frame_id_i    (cur_frame.id),
    .length_code_i (cur_frame.len),
    .extended_i    (cur_frame.ext),
    .remote_i      (cur_frame.rtr),
    .byte0_i       (cur_frame.data[0]),
    .byte1_i       (cur_frame.data[1]),
    .byte2_i       (cur_frame.data[2]),
    .byte3_i       (cur_frame.data[3]),
    .byte4_i       (cur_frame.data[4]),
    .byte5_i       (cur_frame.data[5]),
    .byte6_i       (cur_frame.data[6]),
    .byte7_i       (cur_frame.data[7]),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .text_char_o   (text_char_o),
    .line_end_o    (line_end_o)
  );

  function automatic char_t hex_digit(logic [3:0] nib);
    if (nib > 4'd9) begin
      return char_t'(8'h41 + nib - 4'd10);
    end
    return char_t'(8'h30 + nib);
  endfunction

  function automatic void push_char(char_t ch, logic last);
    line_char_t c;
    c.ch = ch;
    c.last = last;
    due_chars.push_back(c);
  endfunction

  function automatic void format_line(can_frame_t f);
    logic [31:0] id_val;
    logic [3:0] n_bytes;
    int n_digits;
    n_bytes = (f.len > MaxLen) ? MaxLen : f.len;
    if (f.ext) begin
      id_val = {3'b000, f.id};
      n_digits = 8;
    end else begin
      id_val = {21'd0, f.id[10:0]};
      n_digits = 3;
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      push_char(hex_digit(id_val[4*i +: 4]), 1'b0);
    end
    push_char(ChHash, 1'b0);
    if (f.rtr) begin
      push_char(ChR, 1'b0);
      push_char(hex_digit(n_bytes), 1'b0);
    end else begin
      for (int b = 0; b < n_bytes; b++) begin
        push_char(hex_digit(f.data[b][7:4]), 1'b0);
        push_char(hex_digit(f.data[b][3:0]), 1'b0);
      end
    end
    push_char(ChCr, 1'b0);
    push_char(ChLf, 1'b1);
  endfunction

  task automatic queue_frame(logic [28:0] id, logic [3:0] len, logic ext, logic rtr,
                             logic [63:0] data);
    can_frame_t f;
    f.id = id;
    f.len = len;
    f.ext = ext;
    f.rtr = rtr;
    f.data = data;
    frames_pending.push_back(f);
    frames_queued++;
  endtask

  task automatic queue_random_frames(int count);
    for (int n = 0; n < count; n++) begin
      queue_frame(29'($urandom), 4'($urandom_range(15)), 1'($urandom_range(1)),
                  ($urandom_range(3) == 0), {$urandom, $urandom});
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (frames_taken != frames_queued || due_chars.size() != 0);
  endtask

  task automatic report_mismatch(string what, line_char_t exp_c);
    if (mismatches < 10) begin
      $display("%0t: %s: expected char %02h end %0b, got char %02h end %0b",
               $realtime, what, exp_c.ch, exp_c.last, text_char_o, line_end_o);
    end
    mismatches++;
  endtask

  // Driver: a frame is held until its transfer, then the next one may follow.
  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!in_valid || taken_now) begin
      if (frames_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        cur_frame <= frames_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: frame transfers add their line; character transfers are checked.
  always @(posedge clk_i) begin
    line_char_t exp_c;
    if (rst_ni && in_valid && !in_stall_o) begin
      format_line(cur_frame);
      frames_taken <= frames_taken + 1;
      taken_now <= 1'b1;
    end else begin
      taken_now <= 1'b0;
    end
    if (rst_ni && out_valid_o && !out_stall) begin
      if (due_chars.size() == 0) begin
        exp_c.ch = '0;
        exp_c.last = 1'b0;
        report_mismatch("character with no line due", exp_c);
      end else begin
        exp_c = due_chars.pop_front();
        if (text_char_o !== exp_c.ch || line_end_o !== exp_c.last) begin
          report_mismatch("character mismatch", exp_c);
        end
      end
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames: identifier extremes, length saturation and remote requests.
    queue_frame(29'h0, 4'd0, 1'b0, 1'b0, 64'h0);
    queue_frame(29'h7FF, 4'd8, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_frame(29'h1FFF_F800, 4'd1, 1'b0, 1'b0, 64'h0000_0000_0000_00A5);
    queue_frame(29'h1FFF_FFFF, 4'd8, 1'b1, 1'b0, 64'h0);
    queue_frame(29'h0, 4'd0, 1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_frame(29'h1234_5678, 4'd8, 1'b1, 1'b0, 64'hEFCD_AB89_6745_2301);
    queue_frame(29'h0AB_CDEF, 4'd9, 1'b0, 1'b0, 64'h1122_3344_5566_7788);
    queue_frame(29'h155_5555, 4'd15, 1'b1, 1'b0, 64'h8877_6655_4433_2211);
    queue_frame(29'h123, 4'd0, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_frame(29'h1FFF_FFFF, 4'd8, 1'b1, 1'b1, 64'h0);
    queue_frame(29'h7FF, 4'd15, 1'b0, 1'b1, 64'hDEAD_BEEF_CAFE_F00D);
    queue_frame(29'h0AA_AAAA, 4'd3, 1'b1, 1'b1, 64'h0102_0304_0506_0708);
    queue_frame(29'h456, 4'd9, 1'b0, 1'b1, 64'h0);
    for (int l = 1; l < 8; l++) begin
      queue_frame(29'($urandom), 4'(l), 1'(l % 2), 1'b0, {$urandom, $urandom});
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random_frames(125);
    wait_drained();

    send_idle_pct = 77;
    recv_stall_pct = 0;
    queue_random_frames(125);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 77;
    queue_random_frames(125);
    wait_drained();

    send_idle_pct = 32;
    recv_stall_pct = 32;
    queue_random_frames(125);
    wait_drained();

    repeat (40) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/cfta_pkg.sv
design/cfta_nibble_shifter.sv
design/can_frame_to_ascii_line.sv
tb/tb_can_frame_to_ascii_line.sv
